[design/pfc_pkg.sv]
// Shared types, constants and codes of the printf format string checker.
package pfc_pkg;

	// Limits of one format string.
	localparam int unsigned MAX_BYTES       = 4096;
	localparam int unsigned MAX_CONVERSIONS = 32;
	localparam int unsigned MAX_ARGUMENTS   = 64;

	// State widths.
	localparam int unsigned BYTE_CNT_W = $clog2(MAX_BYTES + 2);
	localparam int unsigned CONV_CNT_W = $clog2(MAX_CONVERSIONS + 1);
	localparam int unsigned ARG_CNT_W  = 7;
	localparam int unsigned LIT_CNT_W  = 13;
	localparam int unsigned FIELD_W    = 31;
	localparam logic [FIELD_W-1:0] FIELD_MAX = {FIELD_W{1'b1}};

	// Result queue.
	localparam int unsigned RES_DEPTH = 8;
	localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
	localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

	// Characters of the format syntax.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LO_H  = 8'h68;
	localparam logic [7:0] CH_LO_L  = 8'h6C;
	localparam logic [7:0] CH_LO_J  = 8'h6A;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;
	localparam logic [7:0] CH_LO_T  = 8'h74;
	localparam logic [7:0] CH_UP_L  = 8'h4C;
	localparam logic [7:0] CH_LO_D  = 8'h64;
	localparam logic [7:0] CH_LO_I  = 8'h69;
	localparam logic [7:0] CH_LO_U  = 8'h75;
	localparam logic [7:0] CH_LO_O  = 8'h6F;
	localparam logic [7:0] CH_LO_X  = 8'h78;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] CH_LO_S  = 8'h73;
	localparam logic [7:0] CH_LO_C  = 8'h63;
	localparam logic [7:0] CH_LO_P  = 8'h70;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_LO_E  = 8'h65;
	localparam logic [7:0] CH_UP_E  = 8'h45;
	localparam logic [7:0] CH_LO_F  = 8'h66;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_LO_G  = 8'h67;
	localparam logic [7:0] CH_UP_G  = 8'h47;

	typedef enum logic [3:0] {
		M_LIT    = 4'd0,
		M_PCT    = 4'd1,
		M_FLAGS  = 4'd2,
		M_WIDTH  = 4'd3,
		M_AFTERW = 4'd4,
		M_DOT    = 4'd5,
		M_PREC   = 4'd6,
		M_LEN    = 4'd7,
		M_LEN2   = 4'd8,
		M_CODE   = 4'd9
	} mode_t;

	typedef enum logic [3:0] {
		LM_NONE = 4'd0,
		LM_H    = 4'd1,
		LM_HH   = 4'd2,
		LM_L    = 4'd3,
		LM_LL   = 4'd4,
		LM_J    = 4'd5,
		LM_Z    = 4'd6,
		LM_T    = 4'd7,
		LM_BIGL = 4'd8
	} len_t;

	typedef enum logic [3:0] {
		ERR_NONE       = 4'd0,
		ERR_BYTES      = 4'd1,
		ERR_CONVS      = 4'd2,
		ERR_WIDTH      = 4'd3,
		ERR_PRECISION  = 4'd4,
		ERR_INCOMPLETE = 4'd5,
		ERR_INTLEN     = 4'd6,
		ERR_FLOATLEN   = 4'd7,
		ERR_CONV       = 4'd8,
		ERR_PREC       = 4'd9,
		ERR_FLAGS      = 4'd10,
		ERR_ALT        = 4'd11,
		ERR_ARGS       = 4'd12
	} err_t;

	typedef enum logic [3:0] {
		VT_INT      = 4'd0,
		VT_UINT     = 4'd1,
		VT_LONG     = 4'd2,
		VT_ULONG    = 4'd3,
		VT_LLONG    = 4'd4,
		VT_ULLONG   = 4'd5,
		VT_INTMAX   = 4'd6,
		VT_UINTMAX  = 4'd7,
		VT_SSIZE    = 4'd8,
		VT_SIZE     = 4'd9,
		VT_PTRDIFF  = 4'd10,
		VT_UPTRDIFF = 4'd11,
		VT_DOUBLE   = 4'd12,
		VT_LDOUBLE  = 4'd13,
		VT_STRING   = 4'd14,
		VT_POINTER  = 4'd15
	} vtype_t;

	typedef enum logic [1:0] {
		PK_NONE = 2'd0,
		PK_DEC  = 2'd1,
		PK_STAR = 2'd2
	} pkind_t;

	// One result record.
	typedef struct packed {
		logic [7:0]         conversion_char;
		vtype_t             value_type;
		logic [2:0]         flag_bits;
		logic [FIELD_W-1:0] width_or_literals;
		logic [6:0]         width_argument;
		pkind_t             precision_kind;
		logic [FIELD_W-1:0] precision_value;
		logic [6:0]         precision_argument;
		logic [6:0]         argument_number;
		err_t               error_code;
		logic               last_result;
	} rec_t;

	// Parser state carried from byte to byte.
	typedef struct packed {
		mode_t                 mode;
		logic [BYTE_CNT_W-1:0] byte_count;
		logic [LIT_CNT_W-1:0]  literal_count;
		logic [CONV_CNT_W-1:0] conversion_count;
		logic [ARG_CNT_W-1:0]  argument_count;
		err_t                  latched_error;
		logic                  seen_nul;
		logic [2:0]            flag_marks;
		logic [FIELD_W-1:0]    width_accum;
		logic [6:0]            width_star_index;
		logic [FIELD_W-1:0]    precision_accum;
		pkind_t                precision_mode;
		logic [6:0]            precision_star_index;
		len_t                  length_modifier;
	} state_t;

	// Records produced by one byte, handed to the result queue.
	typedef struct packed {
		logic [1:0] count;
		rec_t       first;
		rec_t       second;
	} push_t;

endpackage

[design/pfc_text_if.sv]
// Input channel: one format string byte per transaction.
interface pfc_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] format_byte;
	logic       last;

	modport source(output valid, output format_byte, output last, input ready);
	modport sink(input valid, input format_byte, input last, output ready);
endinterface

[design/pfc_report_if.sv]
// Output channel: one conversion or summary record per transaction.
interface pfc_report_if;
	logic                          valid;
	logic                          ready;
	logic [7:0]                    conversion_char;
	logic [3:0]                    value_type;
	logic [2:0]                    flag_bits;
	logic [pfc_pkg::FIELD_W-1:0]   width_or_literals;
	logic [6:0]                    width_argument;
	logic [1:0]                    precision_kind;
	logic [pfc_pkg::FIELD_W-1:0]   precision_value;
	logic [6:0]                    precision_argument;
	logic [6:0]                    argument_number;
	logic [3:0]                    error_code;
	logic                          last_result;

	modport source(output valid, output conversion_char, output value_type,
		output flag_bits, output width_or_literals, output width_argument,
		output precision_kind, output precision_value, output precision_argument,
		output argument_number, output error_code, output last_result, input ready);
	modport sink(input valid, input conversion_char, input value_type,
		input flag_bits, input width_or_literals, input width_argument,
		input precision_kind, input precision_value, input precision_argument,
		input argument_number, input error_code, input last_result, output ready);
endinterface

[design/printf_format_string_checker_core.sv]
// Top level of the printf format string checker: input register, parser, result queue.
//
// The text channel takes one byte of a format string per transaction, with
// last set on its final byte. The report channel gives one record for each
// completed conversion and, after the final byte, one summary record with
// last_result set, carrying the literal count, argument count and first error.
// A byte is registered on acceptance and parsed in the next cycle; its records
// land in an eight-entry result queue, and the first record can be taken once it
// has passed the input register and the queue. One byte is taken per cycle while
// ready is high; a final byte that also closes a conversion yields two records,
// which leave the queue one after the other. The parser state is updated by the
// combinational parse step between the input register and the state.
// ready stays high while the queue, counting a byte still being parsed, has
// room for two more records; a stalled receiver fills the queue and then holds
// ready low, with nothing lost. Reset clears the parser to literal text mode
// with all counts zero and empties the queue. After each summary the parser
// returns to that same state for the next string.
module printf_format_string_checker_core (
	input  logic                clk,
	input  logic                arst_n,
	pfc_text_if.sink            text,
	pfc_report_if.source        report
);

	logic                           v_s1;
	logic [7:0]                     byte_s1;
	logic                           last_s1;
	pfc_pkg::state_t                state_q;
	pfc_pkg::state_t                state_nx;
	pfc_pkg::push_t                 step_push;
	pfc_pkg::push_t                 fifo_push;
	pfc_pkg::rec_t                  head;
	logic                           not_empty;
	logic [pfc_pkg::RES_CNT_W-1:0]  count;
	logic [pfc_pkg::RES_CNT_W:0]    occupancy;
	logic                           pop;

	assign occupancy = (pfc_pkg::RES_CNT_W+1)'(count) +
		(v_s1 ? (pfc_pkg::RES_CNT_W+1)'(2) : '0);
	assign text.ready = (occupancy <= (pfc_pkg::RES_CNT_W+1)'(pfc_pkg::RES_DEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= text.valid && text.ready;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1 <= text.format_byte;
			last_s1 <= text.last;
		end
	end

	pfc_step u_step (
		.st   (state_q),
		.ch   (byte_s1),
		.last (last_s1),
		.nx   (state_nx),
		.push (step_push)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (v_s1) begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		fifo_push = step_push;
		if (!v_s1) begin
			fifo_push.count = 2'd0;
		end
	end

	assign pop = report.valid && report.ready;

	pfc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fifo_push),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.count     (count)
	);

	assign report.valid              = not_empty;
	assign report.conversion_char    = head.conversion_char;
	assign report.value_type         = head.value_type;
	assign report.flag_bits          = head.flag_bits;
	assign report.width_or_literals  = head.width_or_literals;
	assign report.width_argument     = head.width_argument;
	assign report.precision_kind     = head.precision_kind;
	assign report.precision_value    = head.precision_value;
	assign report.precision_argument = head.precision_argument;
	assign report.argument_number    = head.argument_number;
	assign report.error_code         = head.error_code;
	assign report.last_result        = head.last_result;

	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && last_s1) |=>
		(state_q.byte_count == '0 && state_q.mode == pfc_pkg::M_LIT))
		else $error("parser state not cleared after a summary");

	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && last_s1) |-> (step_push.count != 2'd0 &&
		(step_push.count == 2'd1 ? step_push.first.last_result :
		step_push.second.last_result)))
		else $error("final byte did not produce a summary record");

	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && step_push.count == 2'd2) |->
		(!step_push.first.last_result && step_push.first.error_code == pfc_pkg::ERR_NONE))
		else $error("conversion record carries a summary mark or an error");

	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !last_s1) |-> (step_push.count != 2'd2))
		else $error("two records from a byte that is not final");

endmodule

[design/pfc_step.sv]
// Next-state logic of the format parser for one byte, with the records it emits.
module pfc_step (
	input  pfc_pkg::state_t st,
	input  logic [7:0]      ch,
	input  logic            last,
	output pfc_pkg::state_t nx,
	output pfc_pkg::push_t  push
);

	function automatic pfc_pkg::state_t fail(pfc_pkg::state_t s, pfc_pkg::err_t code);
		pfc_pkg::state_t r;
		r = s;
		if (r.latched_error == pfc_pkg::ERR_NONE) begin
			r.latched_error = code;
		end
		r.mode = pfc_pkg::M_LIT;
		return r;
	endfunction

	// The text ended while a conversion was still open.
	function automatic pfc_pkg::state_t end_text(pfc_pkg::state_t s);
		pfc_pkg::state_t r;
		r = s;
		if (r.latched_error == pfc_pkg::ERR_NONE && r.mode != pfc_pkg::M_LIT) begin
			if (r.mode == pfc_pkg::M_PCT &&
					r.conversion_count >= pfc_pkg::CONV_CNT_W'(pfc_pkg::MAX_CONVERSIONS)) begin
				r = fail(r, pfc_pkg::ERR_CONVS);
			end else begin
				r = fail(r, pfc_pkg::ERR_INCOMPLETE);
			end
		end
		return r;
	endfunction

	pfc_pkg::state_t             s;
	logic                        go;
	logic                        is_digit;
	logic [pfc_pkg::FIELD_W+3:0] prod;
	logic                        sgn, uns, scp, flt;
	logic [3:0]                  base;
	pfc_pkg::err_t               ferr;
	pfc_pkg::vtype_t             ty;
	logic [pfc_pkg::ARG_CNT_W:0] arg_next;
	logic                        conv_emit;
	pfc_pkg::rec_t               conv_rec;
	pfc_pkg::rec_t               sum_rec;

	assign is_digit = (ch >= pfc_pkg::CH_ZERO) && (ch <= pfc_pkg::CH_NINE);
	assign sgn = (ch == pfc_pkg::CH_LO_D) || (ch == pfc_pkg::CH_LO_I);
	assign uns = (ch == pfc_pkg::CH_LO_U) || (ch == pfc_pkg::CH_LO_O) ||
		(ch == pfc_pkg::CH_LO_X) || (ch == pfc_pkg::CH_UP_X);
	assign scp = (ch == pfc_pkg::CH_LO_S) || (ch == pfc_pkg::CH_LO_C) ||
		(ch == pfc_pkg::CH_LO_P);
	assign flt = (ch == pfc_pkg::CH_LO_A) || (ch == pfc_pkg::CH_UP_A) ||
		(ch == pfc_pkg::CH_LO_E) || (ch == pfc_pkg::CH_UP_E) ||
		(ch == pfc_pkg::CH_LO_F) || (ch == pfc_pkg::CH_UP_F) ||
		(ch == pfc_pkg::CH_LO_G) || (ch == pfc_pkg::CH_UP_G);

	always_comb begin
		s         = st;
		go        = 1'b0;
		prod      = '0;
		base      = '0;
		ferr      = pfc_pkg::ERR_NONE;
		ty        = pfc_pkg::VT_INT;
		arg_next  = '0;
		conv_emit = 1'b0;
		conv_rec  = '0;
		sum_rec   = '0;

		if (s.byte_count <= pfc_pkg::BYTE_CNT_W'(pfc_pkg::MAX_BYTES)) begin
			s.byte_count = s.byte_count + 1'b1;
		end

		if (!s.seen_nul && s.latched_error == pfc_pkg::ERR_NONE) begin
			if (ch == pfc_pkg::CH_NUL) begin
				s = end_text(s);
				s.seen_nul = 1'b1;
			end else begin
				go = 1'b1;
			end
		end else if (ch == pfc_pkg::CH_NUL) begin
			s.seen_nul = 1'b1;
		end

		// Modes only move forward within one byte, so one ordered pass
		// covers every fall-through of the parser.
		if (go && s.mode == pfc_pkg::M_LIT) begin
			if (ch == pfc_pkg::CH_PCT) begin
				s.mode = pfc_pkg::M_PCT;
			end else begin
				s.literal_count = s.literal_count + 1'b1;
			end
			go = 1'b0;
		end

		if (go && s.mode == pfc_pkg::M_PCT) begin
			if (ch == pfc_pkg::CH_PCT) begin
				s.literal_count = s.literal_count + 1'b1;
				s.mode = pfc_pkg::M_LIT;
				go = 1'b0;
			end else if (s.conversion_count >=
					pfc_pkg::CONV_CNT_W'(pfc_pkg::MAX_CONVERSIONS)) begin
				s = fail(s, pfc_pkg::ERR_CONVS);
				go = 1'b0;
			end else begin
				s.flag_marks           = '0;
				s.width_accum          = '0;
				s.width_star_index     = '0;
				s.precision_accum      = '0;
				s.precision_mode       = pfc_pkg::PK_NONE;
				s.precision_star_index = '0;
				s.length_modifier      = pfc_pkg::LM_NONE;
				s.mode                 = pfc_pkg::M_FLAGS;
			end
		end

		if (go && s.mode == pfc_pkg::M_FLAGS) begin
			if (ch == pfc_pkg::CH_MINUS || ch == pfc_pkg::CH_PLUS ||
					ch == pfc_pkg::CH_SPACE || ch == pfc_pkg::CH_HASH ||
					ch == pfc_pkg::CH_ZERO) begin
				if (ch == pfc_pkg::CH_HASH) s.flag_marks[0] = 1'b1;
				if (ch == pfc_pkg::CH_PLUS || ch == pfc_pkg::CH_SPACE) s.flag_marks[1] = 1'b1;
				if (ch == pfc_pkg::CH_ZERO) s.flag_marks[2] = 1'b1;
				go = 1'b0;
			end else if (ch == pfc_pkg::CH_STAR) begin
				s.width_star_index = s.argument_count + 1'b1;
				s.argument_count   = s.argument_count + 1'b1;
				s.mode             = pfc_pkg::M_AFTERW;
				go = 1'b0;
			end else begin
				s.mode = is_digit ? pfc_pkg::M_WIDTH : pfc_pkg::M_AFTERW;
			end
		end

		if (go && s.mode == pfc_pkg::M_WIDTH) begin
			if (is_digit) begin
				prod = ({4'b0, s.width_accum} << 3) + ({4'b0, s.width_accum} << 1) +
					(pfc_pkg::FIELD_W+4)'(ch[3:0]);
				if (prod > {4'b0, pfc_pkg::FIELD_MAX}) begin
					s = fail(s, pfc_pkg::ERR_WIDTH);
				end else begin
					s.width_accum = prod[pfc_pkg::FIELD_W-1:0];
				end
				go = 1'b0;
			end else begin
				s.mode = pfc_pkg::M_AFTERW;
			end
		end

		if (go && s.mode == pfc_pkg::M_AFTERW) begin
			if (ch == pfc_pkg::CH_DOT) begin
				s.mode = pfc_pkg::M_DOT;
				go = 1'b0;
			end else begin
				s.mode = pfc_pkg::M_LEN;
			end
		end

		if (go && s.mode == pfc_pkg::M_DOT) begin
			if (ch == pfc_pkg::CH_STAR) begin
				s.precision_mode       = pfc_pkg::PK_STAR;
				s.precision_star_index = s.argument_count;
				s.argument_count       = s.argument_count + 1'b1;
				s.mode                 = pfc_pkg::M_LEN;
				go = 1'b0;
			end else begin
				s.precision_mode  = pfc_pkg::PK_DEC;
				s.precision_accum = '0;
				s.mode            = pfc_pkg::M_PREC;
			end
		end

		if (go && s.mode == pfc_pkg::M_PREC) begin
			if (is_digit) begin
				prod = ({4'b0, s.precision_accum} << 3) + ({4'b0, s.precision_accum} << 1) +
					(pfc_pkg::FIELD_W+4)'(ch[3:0]);
				if (prod > {4'b0, pfc_pkg::FIELD_MAX}) begin
					s = fail(s, pfc_pkg::ERR_PRECISION);
				end else begin
					s.precision_accum = prod[pfc_pkg::FIELD_W-1:0];
				end
				go = 1'b0;
			end else begin
				s.mode = pfc_pkg::M_LEN;
			end
		end

		if (go && s.mode == pfc_pkg::M_LEN) begin
			go = 1'b0;
			case (ch)
				pfc_pkg::CH_LO_H: begin
					s.length_modifier = pfc_pkg::LM_H;
					s.mode = pfc_pkg::M_LEN2;
				end
				pfc_pkg::CH_LO_L: begin
					s.length_modifier = pfc_pkg::LM_L;
					s.mode = pfc_pkg::M_LEN2;
				end
				pfc_pkg::CH_LO_J: begin
					s.length_modifier = pfc_pkg::LM_J;
					s.mode = pfc_pkg::M_CODE;
				end
				pfc_pkg::CH_LO_Z: begin
					s.length_modifier = pfc_pkg::LM_Z;
					s.mode = pfc_pkg::M_CODE;
				end
				pfc_pkg::CH_LO_T: begin
					s.length_modifier = pfc_pkg::LM_T;
					s.mode = pfc_pkg::M_CODE;
				end
				pfc_pkg::CH_UP_L: begin
					s.length_modifier = pfc_pkg::LM_BIGL;
					s.mode = pfc_pkg::M_CODE;
				end
				default: begin
					s.mode = pfc_pkg::M_CODE;
					go = 1'b1;
				end
			endcase
		end

		if (go && s.mode == pfc_pkg::M_LEN2) begin
			if (s.length_modifier == pfc_pkg::LM_H && ch == pfc_pkg::CH_LO_H) begin
				s.length_modifier = pfc_pkg::LM_HH;
				s.mode = pfc_pkg::M_CODE;
				go = 1'b0;
			end else if (s.length_modifier == pfc_pkg::LM_L && ch == pfc_pkg::CH_LO_L) begin
				s.length_modifier = pfc_pkg::LM_LL;
				s.mode = pfc_pkg::M_CODE;
				go = 1'b0;
			end else begin
				s.mode = pfc_pkg::M_CODE;
			end
		end

		// Conversion letter: classify, check and number the argument.
		if (go && s.mode == pfc_pkg::M_CODE) begin
			if (sgn || uns) begin
				case (s.length_modifier)
					pfc_pkg::LM_NONE, pfc_pkg::LM_H, pfc_pkg::LM_HH: base = 4'd0;
					pfc_pkg::LM_L:  base = 4'd2;
					pfc_pkg::LM_LL: base = 4'd4;
					pfc_pkg::LM_J:  base = 4'd6;
					pfc_pkg::LM_Z:  base = 4'd8;
					pfc_pkg::LM_T:  base = 4'd10;
					default:        ferr = pfc_pkg::ERR_INTLEN;
				endcase
				ty = pfc_pkg::vtype_t'(base | {3'b0, uns});
			end else if (flt) begin
				if (s.length_modifier != pfc_pkg::LM_NONE &&
						s.length_modifier != pfc_pkg::LM_L &&
						s.length_modifier != pfc_pkg::LM_BIGL) begin
					ferr = pfc_pkg::ERR_FLOATLEN;
				end
				ty = (s.length_modifier == pfc_pkg::LM_BIGL) ? pfc_pkg::VT_LDOUBLE :
					pfc_pkg::VT_DOUBLE;
			end else if (scp && s.length_modifier == pfc_pkg::LM_NONE) begin
				if (ch != pfc_pkg::CH_LO_S && s.precision_mode != pfc_pkg::PK_NONE) begin
					ferr = pfc_pkg::ERR_PREC;
				end
				ty = (ch == pfc_pkg::CH_LO_S) ? pfc_pkg::VT_STRING :
					(ch == pfc_pkg::CH_LO_P) ? pfc_pkg::VT_POINTER : pfc_pkg::VT_INT;
			end else begin
				ferr = pfc_pkg::ERR_CONV;
			end

			if (ferr == pfc_pkg::ERR_NONE && scp && s.flag_marks != 3'b0) begin
				ferr = pfc_pkg::ERR_FLAGS;
			end
			if (ferr == pfc_pkg::ERR_NONE && s.flag_marks[0] &&
					(sgn || ch == pfc_pkg::CH_LO_U)) begin
				ferr = pfc_pkg::ERR_ALT;
			end

			if (ferr != pfc_pkg::ERR_NONE) begin
				s = fail(s, ferr);
			end else begin
				arg_next = {1'b0, s.argument_count} + 1'b1;
				if (arg_next > (pfc_pkg::ARG_CNT_W+1)'(pfc_pkg::MAX_ARGUMENTS)) begin
					s.argument_count = arg_next[pfc_pkg::ARG_CNT_W-1:0];
					s = fail(s, pfc_pkg::ERR_ARGS);
				end else begin
					conv_emit = 1'b1;
					conv_rec.conversion_char   = ch;
					conv_rec.value_type        = ty;
					conv_rec.flag_bits         = {(s.length_modifier == pfc_pkg::LM_H ||
						s.length_modifier == pfc_pkg::LM_HH), s.flag_marks[1:0]};
					conv_rec.width_or_literals = s.width_accum;
					conv_rec.width_argument    = s.width_star_index;
					conv_rec.precision_kind    = s.precision_mode;
					conv_rec.precision_value   = (s.precision_mode == pfc_pkg::PK_DEC) ?
						s.precision_accum : '0;
					conv_rec.precision_argument = (s.precision_mode == pfc_pkg::PK_STAR) ?
						s.precision_star_index : '0;
					conv_rec.argument_number   = s.argument_count;
					conv_rec.error_code        = pfc_pkg::ERR_NONE;
					conv_rec.last_result       = 1'b0;
					s.argument_count   = arg_next[pfc_pkg::ARG_CNT_W-1:0];
					s.conversion_count = s.conversion_count + 1'b1;
					s.mode             = pfc_pkg::M_LIT;
				end
			end
		end

		if (last) begin
			if (!s.seen_nul) begin
				s = end_text(s);
			end
			sum_rec.width_or_literals = pfc_pkg::FIELD_W'(s.literal_count);
			sum_rec.argument_number   = s.argument_count;
			sum_rec.error_code        = s.latched_error;
			sum_rec.last_result       = 1'b1;
			// An overlong string overrides every other outcome.
			if (s.byte_count > pfc_pkg::BYTE_CNT_W'(pfc_pkg::MAX_BYTES)) begin
				sum_rec.width_or_literals = '0;
				sum_rec.argument_number   = '0;
				sum_rec.error_code        = pfc_pkg::ERR_BYTES;
			end
			s = '0;
		end

		nx = s;
		push.count  = {1'b0, conv_emit} + {1'b0, last};
		push.first  = conv_emit ? conv_rec : sum_rec;
		push.second = sum_rec;
	end

endmodule

[design/pfc_fifo.sv]
// Result queue that takes up to two records per cycle and gives one.
module pfc_fifo (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pfc_pkg::push_t                 push,
	input  logic                           pop,
	output pfc_pkg::rec_t                  head,
	output logic                           not_empty,
	output logic [pfc_pkg::RES_CNT_W-1:0]  count
);

	pfc_pkg::rec_t                  mem_q [pfc_pkg::RES_DEPTH];
	logic [pfc_pkg::RES_PTR_W-1:0]  wr_ptr_q;
	logic [pfc_pkg::RES_PTR_W-1:0]  rd_ptr_q;
	logic [pfc_pkg::RES_CNT_W-1:0]  count_q;
	logic [pfc_pkg::RES_PTR_W-1:0]  wr_next;

	assign wr_next = wr_ptr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_next] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + pfc_pkg::RES_PTR_W'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + pfc_pkg::RES_CNT_W'(push.count) -
				pfc_pkg::RES_CNT_W'(pop);
		end
	end

	assign head      = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign count     = count_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pfc_pkg::RES_CNT_W'(pfc_pkg::RES_DEPTH))
		else $error("result queue occupancy beyond its depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(push.count != 2'd0) |->
		((pfc_pkg::RES_CNT_W+1)'(count_q) + (pfc_pkg::RES_CNT_W+1)'(push.count) <=
		(pfc_pkg::RES_CNT_W+1)'(pfc_pkg::RES_DEPTH) + (pfc_pkg::RES_CNT_W+1)'(pop)))
		else $error("result queue written while full");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("result queue read while empty");

endmodule
